[rtl/core/sntc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Session nonce and TTL checker package
// Shared types, operation and status codes, and register indexes.
// ----------------------------------------------------------------------------
package sntc_pkg;

   localparam int unsigned TimeWidth    = 48;
   localparam int unsigned Time32Width  = 32;
   localparam int unsigned NonceWidth   = 16;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 48;

   localparam logic [2:0] OP_CHECK_DATA = 3'd0;
   localparam logic [2:0] OP_CHECK_AUTH = 3'd1;
   localparam logic [2:0] OP_SEND_DATA  = 3'd2;
   localparam logic [2:0] OP_SEND_AUTH  = 3'd3;
   localparam logic [2:0] OP_OPEN       = 3'd4;
   localparam logic [2:0] OP_CLOSE      = 3'd5;

   localparam logic [3:0] ST_OK            = 4'd0;
   localparam logic [3:0] ST_NO_SESSION    = 4'd1;
   localparam logic [3:0] ST_CRYPTO        = 4'd2;
   localparam logic [3:0] ST_ROLLBACK      = 4'd3;
   localparam logic [3:0] ST_SESSION_TIME  = 4'd4;
   localparam logic [3:0] ST_TTL           = 4'd5;
   localparam logic [3:0] ST_NONCE_LIMIT   = 4'd6;
   localparam logic [3:0] ST_REPLAY        = 4'd7;
   localparam logic [3:0] ST_EMPTY         = 4'd8;
   localparam logic [3:0] ST_OPEN_REJECTED = 4'd9;

   localparam logic [CsrIdxWidth-1:0] REG_SESSION_START = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_SESSION   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_NONCE     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_TTL_PAD       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_ORDER_MODE    = 3'd4;

   typedef struct packed {
      logic [2:0]             op;
      logic [TimeWidth-1:0]   now_ms;
      logic                   crypto_ok;
      logic [NonceWidth-1:0]  msg_nonce;
      logic [Time32Width-1:0] msg_valid_until_ms;
      logic                   payload_empty;
      logic                   keys_valid;
   } req_type;

   typedef struct packed {
      logic [3:0]             status;
      logic [NonceWidth-1:0]  tx_nonce_out;
      logic [Time32Width-1:0] tx_valid_until_ms;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0]   session_start_ms;
      logic [Time32Width-1:0] max_session_time_ms;
      logic [NonceWidth-1:0]  nonce_limit;
      logic [Time32Width-1:0] tx_pad_ms;
      logic                   nonce_order_mode;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      req_type              item;
      logic                 rollback;
      logic [TimeWidth-1:0] age_ms;
   } staged_type;

endpackage
`default_nettype wire

[rtl/core/sntc_age_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Input stage
// Registers an accepted transfer together with its session age and rollback.
// ----------------------------------------------------------------------------
module sntc_age_stage import sntc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   input  wire cfg_type    cfg,
   input  wire logic       advance,
   output staged_type      stg
);

   logic                 valid_ff, valid_in;
   req_type              item_ff;
   logic                 rollback_ff;
   logic [TimeWidth-1:0] age_ff;
   logic [TimeWidth:0]   diff;
   logic                 take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign diff      = {1'b0, req_data.now_ms} - {1'b0, cfg.session_start_ms};

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff     <= req_data;
         rollback_ff <= diff[TimeWidth];
         age_ff      <= diff[TimeWidth-1:0];
      end
   end

   assign stg = '{valid: valid_ff, item: item_ff, rollback: rollback_ff, age_ms: age_ff};

endmodule
`default_nettype wire

[rtl/core/sntc_session_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Session core
// Holds the session flag and nonces and judges the staged operation.
// ----------------------------------------------------------------------------
module sntc_session_core import sntc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire staged_type stg,
   input  wire cfg_type    cfg,
   input  wire logic       advance,
   output rsp_type         result
);

   logic                  session_valid_ff, session_valid_in;
   logic [NonceWidth-1:0] rx_last_ff, rx_last_in;
   logic [NonceWidth-1:0] tx_last_ff, tx_last_in;
   logic                  age_over_max;
   logic                  age_over_ttl;
   logic [Time32Width:0]  age_pad;
   logic                  pad_over_max;
   logic                  order_ok;
   logic [NonceWidth:0]   rx_next;
   logic [NonceWidth-1:0] tx_next;
   req_type               it;

   assign it           = stg.item;
   assign age_over_max = stg.age_ms > {{(TimeWidth-Time32Width){1'b0}}, cfg.max_session_time_ms};
   assign age_over_ttl = stg.age_ms > {{(TimeWidth-Time32Width){1'b0}}, it.msg_valid_until_ms};
   assign age_pad      = {1'b0, stg.age_ms[Time32Width-1:0]} + {1'b0, cfg.tx_pad_ms};
   assign pad_over_max = age_pad > {1'b0, cfg.max_session_time_ms};
   assign rx_next      = {1'b0, rx_last_ff} + {{NonceWidth{1'b0}}, 1'b1};
   assign tx_next      = tx_last_ff + {{(NonceWidth-1){1'b0}}, 1'b1};

   always_comb begin
      if (it.op == OP_CHECK_AUTH) begin
         order_ok = (it.msg_nonce == '0);
      end else if (cfg.nonce_order_mode) begin
         order_ok = it.msg_nonce > rx_last_ff;
      end else begin
         order_ok = {1'b0, it.msg_nonce} == rx_next;
      end
   end

   always_comb begin
      session_valid_in = session_valid_ff;
      rx_last_in       = rx_last_ff;
      tx_last_in       = tx_last_ff;
      result           = '0;
      result.status    = ST_OK;
      case (it.op) inside
         OP_CHECK_DATA, OP_CHECK_AUTH: begin
            if (!session_valid_ff) begin
               result.status = ST_NO_SESSION;
            end else if (!it.crypto_ok) begin
               result.status = ST_CRYPTO;
            end else if (stg.rollback) begin
               result.status = ST_ROLLBACK;
            end else if (age_over_max) begin
               result.status = ST_SESSION_TIME;
            end else if (age_over_ttl) begin
               result.status = ST_TTL;
            end else if (it.msg_nonce > cfg.nonce_limit) begin
               result.status = ST_NONCE_LIMIT;
            end else if (!order_ok) begin
               result.status = ST_REPLAY;
            end else begin
               rx_last_in = it.msg_nonce;
               if (it.op == OP_CHECK_DATA && it.payload_empty) begin
                  result.status = ST_EMPTY;
               end
            end
         end
         OP_SEND_DATA, OP_SEND_AUTH: begin
            if ((it.op == OP_SEND_AUTH) ? (tx_last_ff != '0)
                                        : (tx_last_ff >= cfg.nonce_limit)) begin
               result.status = ST_NONCE_LIMIT;
            end else if (!session_valid_ff) begin
               result.status = ST_NO_SESSION;
            end else if (stg.rollback) begin
               result.status = ST_ROLLBACK;
            end else if (age_over_max || pad_over_max) begin
               result.status = ST_SESSION_TIME;
            end else if (!it.crypto_ok) begin
               result.status = ST_CRYPTO;
            end else begin
               tx_last_in               = tx_next;
               result.tx_nonce_out      = (it.op == OP_SEND_AUTH) ? '0 : tx_next;
               result.tx_valid_until_ms = age_pad[Time32Width-1:0];
            end
         end
         OP_OPEN: begin
            if (!it.keys_valid) begin
               result.status = ST_OPEN_REJECTED;
            end else begin
               rx_last_in       = '0;
               tx_last_in       = '0;
               session_valid_in = 1'b1;
            end
         end
         OP_CLOSE: begin
            session_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_valid_ff <= 1'b0;
         rx_last_ff       <= '0;
         tx_last_ff       <= '0;
      end else if (advance) begin
         session_valid_ff <= session_valid_in;
         rx_last_ff       <= rx_last_in;
         tx_last_ff       <= tx_last_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/session_nonce_ttl_checker_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Session nonce and TTL checker
// Freshness and anti-replay checks for received frames, and nonce and
// valid-until generation for sent frames, of one secure session.
// ----------------------------------------------------------------------------
// Each request transfer on req_ carries one operation and yields exactly one
// response transfer on rsp_, in order. A request is registered on acceptance
// together with its session age, then judged against the session state and
// written to the response register once that register is free. One transfer
// is accepted every cycle while the receiver does not stall; the session
// state update of one operation is visible to the very next one.
// When the receiver stalls, the response register holds; the request
// register takes one more transfer only if it is empty, then req_ready drops.
// The csr_ port writes one register per cycle with csr_we; the user must
// see that it is written only while no transfer is in flight, which the
// block itself does not enforce. Reset is synchronous and clears the
// session, both nonces and the registers to their defaults.
// ----------------------------------------------------------------------------
module session_nonce_ttl_checker_unit import sntc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   staged_type stg;
   rsp_type    result;
   logic       advance;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   assign advance = stg.valid && (!rsp_valid_ff || rsp_ready);

   sntc_age_stage u_age_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .advance   (advance),
      .stg       (stg)
   );

   sntc_session_core u_session_core (
      .clock   (clock),
      .reset   (reset),
      .stg     (stg),
      .cfg     (cfg_ff),
      .advance (advance),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_start_ms    <= '0;
         cfg_ff.max_session_time_ms <= '1;
         cfg_ff.nonce_limit         <= '1;
         cfg_ff.tx_pad_ms           <= '0;
         cfg_ff.nonce_order_mode    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SESSION_START: cfg_ff.session_start_ms    <= csr_wdata[TimeWidth-1:0];
            REG_MAX_SESSION:   cfg_ff.max_session_time_ms <= csr_wdata[Time32Width-1:0];
            REG_MAX_NONCE:     cfg_ff.nonce_limit         <= csr_wdata[NonceWidth-1:0];
            REG_TTL_PAD:       cfg_ff.tx_pad_ms           <= csr_wdata[Time32Width-1:0];
            REG_ORDER_MODE:    cfg_ff.nonce_order_mode    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
